>>> rtl/core/aar_pkg.sv
// Shared types, widths and constants for the axis-angle rotation matrix pipeline.
// No dependencies; every other file in rtl/core imports this package.
package aar_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int CORDIC_STAGES   = 16;
    localparam int MAX_STAGES      = 32;

    localparam int CW     = COMPONENT_WIDTH;
    localparam int SUM_W  = 2 * CW;
    localparam int ROOT_W = CW;
    localparam int Q_W    = 31;
    localparam int NUM_W  = CW + Q_W;
    localparam int UNIT_W = 32;
    localparam int CRD_W  = 34;
    localparam int ENT_W  = 16;

    localparam logic signed [CRD_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CRD_W-1:0] Q30_ONE  = 34'sd1073741824;
    localparam logic signed [ENT_W-1:0] ONE_Q14  = 16'sd16384;

    typedef struct packed {
        logic signed [CW-1:0] axis_x;
        logic signed [CW-1:0] axis_y;
        logic signed [CW-1:0] axis_z;
        logic [15:0]          turn_angle;
    } axis_item_t;

    typedef struct packed {
        logic signed [ENT_W-1:0] m00;
        logic signed [ENT_W-1:0] m01;
        logic signed [ENT_W-1:0] m02;
        logic signed [ENT_W-1:0] m10;
        logic signed [ENT_W-1:0] m11;
        logic signed [ENT_W-1:0] m12;
        logic signed [ENT_W-1:0] m20;
        logic signed [ENT_W-1:0] m21;
        logic signed [ENT_W-1:0] m22;
        logic                    axis_zero;
    } matrix_item_t;

    typedef struct packed {
        logic valid;
        logic zero;
    } lane_ctl_t;

    // Angle step of CORDIC stage idx, in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/aar_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on aar_pkg; carries the axis magnitudes and signs alongside.
module aar_sqrt (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  aar_pkg::lane_ctl_t                      ctl_in,
    input  logic [aar_pkg::SUM_W-1:0]               sum_in,
    input  logic [2:0][aar_pkg::CW-1:0]             mag_in,
    input  logic [2:0]                              neg_in,
    output aar_pkg::lane_ctl_t                      ctl_out,
    output logic [aar_pkg::ROOT_W-1:0]              root_out,
    output logic [2:0][aar_pkg::CW-1:0]             mag_out,
    output logic [2:0]                              neg_out
);
    import aar_pkg::*;

    localparam int RW    = ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    lane_ctl_t             ctl_reg  [RW];
    logic [REM_W-1:0]      rem_reg  [RW];
    logic [RW-1:0]         root_reg [RW];
    logic [SUM_W-1:0]      sum_reg  [RW];
    logic [2:0][CW-1:0]    mag_reg  [RW];
    logic [2:0]            neg_reg  [RW];

    genvar k;
    for (k = 0; k < RW; k++)
    begin : g_stage
        lane_ctl_t          ctl_i;
        logic [REM_W-1:0]   rem_i;
        logic [RW-1:0]      root_i;
        logic [SUM_W-1:0]   sum_i;
        logic [2:0][CW-1:0] mag_i;
        logic [2:0]         neg_i;
        logic [REM_W+1:0]   cur;
        logic [REM_W+1:0]   trial;
        logic [REM_W+1:0]   diff;

        if (k == 0)
        begin : g_first
            assign ctl_i  = ctl_in;
            assign rem_i  = '0;
            assign root_i = '0;
            assign sum_i  = sum_in;
            assign mag_i  = mag_in;
            assign neg_i  = neg_in;
        end
        else
        begin : g_next
            assign ctl_i  = ctl_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign sum_i  = sum_reg[k-1];
            assign mag_i  = mag_reg[k-1];
            assign neg_i  = neg_reg[k-1];
        end

        // Bring down the next two radicand bits and try the root bit as one.
        assign cur   = {rem_i, sum_i[SUM_W-1 -: 2]};
        assign trial = {2'b00, root_i, 2'b01};
        assign diff  = cur - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctl_reg[k] <= ctl_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cur >= trial)
                begin
                    rem_reg[k]  <= diff[REM_W-1:0];
                    root_reg[k] <= {root_i[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= cur[REM_W-1:0];
                    root_reg[k] <= {root_i[RW-2:0], 1'b0};
                end
                sum_reg[k] <= {sum_i[SUM_W-3:0], 2'b00};
                mag_reg[k] <= mag_i;
                neg_reg[k] <= neg_i;
            end
        end
    end

    assign ctl_out  = ctl_reg[RW-1];
    assign root_out = root_reg[RW-1];
    assign mag_out  = mag_reg[RW-1];
    assign neg_out  = neg_reg[RW-1];

endmodule

>>> rtl/core/aar_div.sv
// Pipelined rounded division of each axis magnitude by the root, three lanes.
// Depends on aar_pkg; one quotient bit per register stage, Q1.30 unit vector out.
module aar_div (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  aar_pkg::lane_ctl_t                      ctl_in,
    input  logic [aar_pkg::ROOT_W-1:0]              root_in,
    input  logic [2:0][aar_pkg::CW-1:0]             mag_in,
    input  logic [2:0]                              neg_in,
    output aar_pkg::lane_ctl_t                      ctl_out,
    output logic [2:0][aar_pkg::UNIT_W-1:0]         unit_out
);
    import aar_pkg::*;

    localparam int RW = ROOT_W;

    lane_ctl_t             ctl_reg  [Q_W];
    logic [RW-1:0]         root_reg [Q_W];
    logic [2:0][NUM_W-1:0] num_reg  [Q_W];
    logic [2:0][Q_W-1:0]   q_reg    [Q_W];
    logic [2:0]            neg_reg  [Q_W];

    genvar k;
    for (k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int BIT = Q_W - 1 - k;

        lane_ctl_t             ctl_i;
        logic [RW-1:0]         root_i;
        logic [2:0][NUM_W-1:0] num_i;
        logic [2:0][Q_W-1:0]   q_i;
        logic [2:0]            neg_i;
        logic [NUM_W-1:0]      dvs;
        logic [2:0][NUM_W-1:0] num_next;
        logic [2:0][Q_W-1:0]   q_next;

        if (k == 0)
        begin : g_first
            // Numerator is mag * 2^30 plus half the divisor for rounding.
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign num_i[l] = {1'b0, mag_in[l], {Q_W-1{1'b0}}}
                                + {{(NUM_W-RW){1'b0}}, 1'b0, root_in[RW-1:1]};
            end
            assign ctl_i  = ctl_in;
            assign root_i = root_in;
            assign q_i    = '0;
            assign neg_i  = neg_in;
        end
        else
        begin : g_next
            assign ctl_i  = ctl_reg[k-1];
            assign root_i = root_reg[k-1];
            assign num_i  = num_reg[k-1];
            assign q_i    = q_reg[k-1];
            assign neg_i  = neg_reg[k-1];
        end

        assign dvs = {{(NUM_W-RW){1'b0}}, root_i} << BIT;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                q_next[l] = q_i[l];
                if (num_i[l] >= dvs)
                begin
                    num_next[l]    = num_i[l] - dvs;
                    q_next[l][BIT] = 1'b1;
                end
                else
                begin
                    num_next[l] = num_i[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctl_reg[k] <= ctl_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= root_i;
                num_reg[k]  <= num_next;
                q_reg[k]    <= q_next;
                neg_reg[k]  <= neg_i;
            end
        end
    end

    assign ctl_out = ctl_reg[Q_W-1];

    for (genvar l = 0; l < 3; l++)
    begin : g_sign
        assign unit_out[l] = neg_reg[Q_W-1][l] ? (UNIT_W'(0) - {1'b0, q_reg[Q_W-1][l]})
                                               : {1'b0, q_reg[Q_W-1][l]};
    end

endmodule

>>> rtl/core/aar_cordic.sv
// Rotation-mode CORDIC for cosine and sine, one stage per register, then a delay line.
// Depends on aar_pkg (gain, widths, arctangent table).
module aar_cordic #(
    parameter int STAGES = aar_pkg::CORDIC_STAGES
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [15:0]                             angle,
    output logic signed [aar_pkg::CRD_W-1:0]        cos_out,
    output logic signed [aar_pkg::CRD_W-1:0]        sin_out
);
    import aar_pkg::*;

    localparam int RUN   = (STAGES < MAX_STAGES) ? STAGES : MAX_STAGES;
    localparam int DELAY = ROOT_W + Q_W - RUN;

    logic signed [CRD_W-1:0] cx_reg   [RUN];
    logic signed [CRD_W-1:0] cy_reg   [RUN];
    logic signed [CRD_W-1:0] z_reg    [RUN];
    logic                    flip_reg [RUN];
    logic signed [CRD_W-1:0] dc_reg   [DELAY];
    logic signed [CRD_W-1:0] ds_reg   [DELAY];

    // Fold to a quarter turn either side of zero; the half turn is a sign flip.
    logic        flip0;
    logic [15:0] z16;
    logic signed [CRD_W-1:0] z0;

    assign flip0 = angle[15] ^ angle[14];
    assign z16   = flip0 ? {~angle[15], angle[14:0]} : angle;
    assign z0    = {{(CRD_W-32){z16[15]}}, z16, 16'b0};

    genvar k;
    for (k = 0; k < RUN; k++)
    begin : g_stage
        logic signed [CRD_W-1:0] cx_i;
        logic signed [CRD_W-1:0] cy_i;
        logic signed [CRD_W-1:0] z_i;
        logic                    flip_i;
        logic signed [CRD_W-1:0] dx;
        logic signed [CRD_W-1:0] dy;
        logic signed [CRD_W-1:0] at;

        if (k == 0)
        begin : g_first
            assign cx_i   = GAIN_Q30;
            assign cy_i   = '0;
            assign z_i    = z0;
            assign flip_i = flip0;
        end
        else
        begin : g_next
            assign cx_i   = cx_reg[k-1];
            assign cy_i   = cy_reg[k-1];
            assign z_i    = z_reg[k-1];
            assign flip_i = flip_reg[k-1];
        end

        assign dx = cy_i >>> k;
        assign dy = cx_i >>> k;
        assign at = $signed({{(CRD_W-32){1'b0}}, atan_turn(5'(k))});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_i[CRD_W-1])
                begin
                    cx_reg[k] <= cx_i - dx;
                    cy_reg[k] <= cy_i + dy;
                    z_reg[k]  <= z_i - at;
                end
                else
                begin
                    cx_reg[k] <= cx_i + dx;
                    cy_reg[k] <= cy_i - dy;
                    z_reg[k]  <= z_i + at;
                end
                flip_reg[k] <= flip_i;
            end
        end
    end

    // The delay line lines the result up with the square root and divider.
    for (k = 0; k < DELAY; k++)
    begin : g_delay
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dc_reg[k] <= flip_reg[RUN-1] ? -cx_reg[RUN-1] : cx_reg[RUN-1];
                    ds_reg[k] <= flip_reg[RUN-1] ? -cy_reg[RUN-1] : cy_reg[RUN-1];
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dc_reg[k] <= dc_reg[k-1];
                    ds_reg[k] <= ds_reg[k-1];
                end
            end
        end
    end

    assign cos_out = dc_reg[DELAY-1];
    assign sin_out = ds_reg[DELAY-1];

endmodule

>>> rtl/core/aar_matrix.sv
// Rodrigues matrix assembly: three multiply and sum stages, rounding to Q1.14.
// Depends on aar_pkg for widths, item type and fixed-point constants.
module aar_matrix (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  aar_pkg::lane_ctl_t                      ctl_in,
    input  logic [2:0][aar_pkg::UNIT_W-1:0]         unit_in,
    input  logic signed [aar_pkg::CRD_W-1:0]        cos_in,
    input  logic signed [aar_pkg::CRD_W-1:0]        sin_in,
    output logic                                    valid_out,
    output aar_pkg::matrix_item_t                   item_out
);
    import aar_pkg::*;

    function automatic logic signed [CRD_W-1:0] mul_q30(
        input logic signed [CRD_W-1:0] a,
        input logic signed [CRD_W-1:0] b
    );
        logic signed [2*CRD_W-1:0] p;
        p = a * b;
        p = p + $signed({{(2*CRD_W-30){1'b0}}, 1'b1, 29'b0});
        return p[CRD_W+29:30];
    endfunction

    function automatic logic signed [ENT_W-1:0] to_q14(input logic signed [CRD_W-1:0] v);
        logic signed [CRD_W-1:0] w;
        logic signed [ENT_W-1:0] r;
        w = (v + $signed({{(CRD_W-16){1'b0}}, 1'b1, 15'b0})) >>> 16;
        if (w > $signed({{(CRD_W-ENT_W){1'b0}}, ONE_Q14}))
            r = ONE_Q14;
        else if (w < -$signed({{(CRD_W-ENT_W){1'b0}}, ONE_Q14}))
            r = -ONE_Q14;
        else
            r = w[ENT_W-1:0];
        return r;
    endfunction

    logic signed [CRD_W-1:0] n [3];

    for (genvar l = 0; l < 3; l++)
    begin : g_ext
        assign n[l] = $signed({{(CRD_W-UNIT_W){unit_in[l][UNIT_W-1]}}, unit_in[l]});
    end

    lane_ctl_t               ctl1_reg, ctl2_reg;
    logic signed [CRD_W-1:0] pp_reg [6];
    logic signed [CRD_W-1:0] sp1_reg [3];
    logic signed [CRD_W-1:0] sp2_reg [3];
    logic signed [CRD_W-1:0] tp_reg [6];
    logic signed [CRD_W-1:0] c1_reg, c2_reg, t1_reg;
    logic                    valid_reg;
    matrix_item_t            item_reg;

    // Products are ordered xx, yy, zz, xy, xz, yz.
    logic signed [CRD_W-1:0] e [9];
    logic signed [ENT_W-1:0] q [9];

    always_comb
    begin
        e[0] = c2_reg + tp_reg[0];
        e[1] = tp_reg[3] - sp2_reg[2];
        e[2] = tp_reg[4] + sp2_reg[1];
        e[3] = tp_reg[3] + sp2_reg[2];
        e[4] = c2_reg + tp_reg[1];
        e[5] = tp_reg[5] - sp2_reg[0];
        e[6] = tp_reg[4] - sp2_reg[1];
        e[7] = tp_reg[5] + sp2_reg[0];
        e[8] = c2_reg + tp_reg[2];
        for (int i = 0; i < 9; i++)
        begin
            q[i] = to_q14(e[i]);
        end
        // A zero axis has no direction; the identity stands in.
        if (ctl2_reg.zero)
        begin
            for (int i = 0; i < 9; i++)
            begin
                q[i] = (i == 0 || i == 4 || i == 8) ? ONE_Q14 : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg  <= '0;
            ctl2_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl1_reg  <= ctl_in;
            ctl2_reg  <= ctl1_reg;
            valid_reg <= ctl2_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[0] <= mul_q30(n[0], n[0]);
            pp_reg[1] <= mul_q30(n[1], n[1]);
            pp_reg[2] <= mul_q30(n[2], n[2]);
            pp_reg[3] <= mul_q30(n[0], n[1]);
            pp_reg[4] <= mul_q30(n[0], n[2]);
            pp_reg[5] <= mul_q30(n[1], n[2]);
            for (int l = 0; l < 3; l++)
            begin
                sp1_reg[l] <= mul_q30(sin_in, n[l]);
                sp2_reg[l] <= sp1_reg[l];
            end
            c1_reg <= cos_in;
            t1_reg <= Q30_ONE - cos_in;
            for (int i = 0; i < 6; i++)
            begin
                tp_reg[i] <= mul_q30(t1_reg, pp_reg[i]);
            end
            c2_reg <= c1_reg;
            item_reg.m00       <= q[0];
            item_reg.m01       <= q[1];
            item_reg.m02       <= q[2];
            item_reg.m10       <= q[3];
            item_reg.m11       <= q[4];
            item_reg.m12       <= q[5];
            item_reg.m20       <= q[6];
            item_reg.m21       <= q[7];
            item_reg.m22       <= q[8];
            item_reg.axis_zero <= ctl2_reg.zero;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

>>> rtl/core/axis_angle_rotation_matrix.sv
// Top level of the axis-angle to rotation matrix pipeline.
// Depends on aar_pkg, aar_sqrt, aar_div, aar_cordic and aar_matrix.
//
// Input channel axis (axis_valid / axis_stall): one beat carries an axis of three
// signed components and a binary angle. Output channel matrix (matrix_valid /
// matrix_stall): one beat carries the nine Q1.14 entries and the zero-axis flag.
// Every input beat gives exactly one output beat, in order.
//
// A beat passes through 52 registers: one for the squares (loaded at the accepting
// edge), 16 for the square root (one root bit per stage), 31 for the divider (one
// quotient bit per stage), three for the products and sums, and the output
// register. The CORDIC runs beside the root and divider and is delayed to match.
// Throughput is one beat per cycle while axis_stall is low.
//
// Reset clears all valid bits; no clearing pass is needed. When the receiver
// stalls, the output register holds its beat and the pipeline still moves one
// more beat into a skid register; axis_stall rises only while that register is
// full, and then the whole pipeline holds with nothing dropped or repeated.
module axis_angle_rotation_matrix #(
    parameter int CORDIC_STAGES = aar_pkg::CORDIC_STAGES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   axis_valid,
    output logic                   axis_stall,
    input  aar_pkg::axis_item_t    axis,
    output logic                   matrix_valid,
    input  logic                   matrix_stall,
    output aar_pkg::matrix_item_t  matrix
);
    import aar_pkg::*;

    logic en;

    // Squares stage.
    logic signed [CW-1:0] comp [3];
    logic [2:0][CW-1:0]   mag_next;
    logic [2:0]           neg_next;
    logic [SUM_W-1:0]     sum_next;
    lane_ctl_t            s1_ctl_next;

    lane_ctl_t            s1_ctl_reg;
    logic [SUM_W-1:0]     s1_sum_reg;
    logic [2:0][CW-1:0]   s1_mag_reg;
    logic [2:0]           s1_neg_reg;
    logic [15:0]          s1_angle_reg;

    assign comp[0] = axis.axis_x;
    assign comp[1] = axis.axis_y;
    assign comp[2] = axis.axis_z;

    for (genvar l = 0; l < 3; l++)
    begin : g_mag
        assign neg_next[l] = comp[l][CW-1];
        assign mag_next[l] = comp[l][CW-1] ? (CW'(0) - comp[l]) : comp[l];
    end

    assign sum_next = ({{CW{1'b0}}, mag_next[0]} * {{CW{1'b0}}, mag_next[0]})
                    + ({{CW{1'b0}}, mag_next[1]} * {{CW{1'b0}}, mag_next[1]})
                    + ({{CW{1'b0}}, mag_next[2]} * {{CW{1'b0}}, mag_next[2]});

    assign s1_ctl_next.valid = axis_valid;
    assign s1_ctl_next.zero  = (mag_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sum_reg   <= sum_next;
            s1_mag_reg   <= mag_next;
            s1_neg_reg   <= neg_next;
            s1_angle_reg <= axis.turn_angle;
        end
    end

    lane_ctl_t                sq_ctl;
    logic [ROOT_W-1:0]        sq_root;
    logic [2:0][CW-1:0]       sq_mag;
    logic [2:0]               sq_neg;
    lane_ctl_t                dv_ctl;
    logic [2:0][UNIT_W-1:0]   dv_unit;
    logic signed [CRD_W-1:0]  cr_cos;
    logic signed [CRD_W-1:0]  cr_sin;
    logic                     mt_valid;
    matrix_item_t             mt_item;

    aar_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (s1_ctl_reg),
        .sum_in   (s1_sum_reg),
        .mag_in   (s1_mag_reg),
        .neg_in   (s1_neg_reg),
        .ctl_out  (sq_ctl),
        .root_out (sq_root),
        .mag_out  (sq_mag),
        .neg_out  (sq_neg)
    );

    aar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (sq_ctl),
        .root_in  (sq_root),
        .mag_in   (sq_mag),
        .neg_in   (sq_neg),
        .ctl_out  (dv_ctl),
        .unit_out (dv_unit)
    );

    aar_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk     (clk),
        .en      (en),
        .angle   (s1_angle_reg),
        .cos_out (cr_cos),
        .sin_out (cr_sin)
    );

    aar_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (dv_ctl),
        .unit_in   (dv_unit),
        .cos_in    (cr_cos),
        .sin_in    (cr_sin),
        .valid_out (mt_valid),
        .item_out  (mt_item)
    );

    // Output register with one skid entry.
    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    matrix_item_t out_reg, skid_reg;
    logic         take;
    logic         load_from_skid, load_from_pipe, load_skid;

    assign take = out_valid_reg && !matrix_stall;
    assign en   = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_from_skid  = 1'b0;
        load_from_pipe  = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                load_from_skid  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            load_from_pipe = 1'b1;
            out_valid_next = mt_valid;
        end
        else if (mt_valid)
        begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_skid)
        begin
            out_reg <= skid_reg;
        end
        else if (load_from_pipe)
        begin
            out_reg <= mt_item;
        end
        if (load_skid)
        begin
            skid_reg <= mt_item;
        end
    end

    assign axis_stall   = skid_valid_reg;
    assign matrix_valid = out_valid_reg;
    assign matrix       = out_reg;

endmodule

>>> rtl/core/aar_props.sv
// Port-level properties of the rotation matrix block, bound to the top level.
// Depends on aar_pkg for the item types.
module aar_props (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  axis_stall,
    input logic                  matrix_valid,
    input logic                  matrix_stall,
    input aar_pkg::matrix_item_t matrix
);
    import aar_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_valid && matrix_stall |=> matrix_valid && $stable(matrix))
        else $error("output beat changed while stalled");

    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_valid && matrix.axis_zero |->
            matrix.m00 == ONE_Q14 && matrix.m11 == ONE_Q14 && matrix.m22 == ONE_Q14 &&
            matrix.m01 == 0 && matrix.m02 == 0 && matrix.m10 == 0 &&
            matrix.m12 == 0 && matrix.m20 == 0 && matrix.m21 == 0)
        else $error("zero axis did not give the identity");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_valid |->
            matrix.m00 <= ONE_Q14 && matrix.m00 >= -ONE_Q14 &&
            matrix.m01 <= ONE_Q14 && matrix.m01 >= -ONE_Q14 &&
            matrix.m02 <= ONE_Q14 && matrix.m02 >= -ONE_Q14 &&
            matrix.m10 <= ONE_Q14 && matrix.m10 >= -ONE_Q14 &&
            matrix.m11 <= ONE_Q14 && matrix.m11 >= -ONE_Q14 &&
            matrix.m12 <= ONE_Q14 && matrix.m12 >= -ONE_Q14 &&
            matrix.m20 <= ONE_Q14 && matrix.m20 >= -ONE_Q14 &&
            matrix.m21 <= ONE_Q14 && matrix.m21 >= -ONE_Q14 &&
            matrix.m22 <= ONE_Q14 && matrix.m22 >= -ONE_Q14)
        else $error("matrix entry outside plus or minus one");

    a_backpr: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(axis_stall) |-> $past(matrix_valid && matrix_stall))
        else $error("input stalled without a stalled output beat");

endmodule

bind axis_angle_rotation_matrix aar_props u_aar_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .axis_stall   (axis_stall),
    .matrix_valid (matrix_valid),
    .matrix_stall (matrix_stall),
    .matrix       (matrix)
);

>>> sim/aar_matrix_checker.sv
// Checker for the axis-angle rotation matrix block: watches both channels,
// predicts each matrix from the accepted axis beat and compares. Uses aar_pkg.
`timescale 1ns / 100ps
module aar_matrix_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  axis_valid,
    input  logic                  axis_stall,
    input  aar_pkg::axis_item_t   axis,
    input  logic                  matrix_valid,
    input  logic                  matrix_stall,
    input  aar_pkg::matrix_item_t matrix,
    output int                    fail_count,
    output int                    pending_count
);
    import aar_pkg::*;

    matrix_item_t pending_matrices[$];

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return fshift(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic logic signed [15:0] to_entry(longint v);
        longint w;
        w = fshift(v + (64'sd1 <<< 15), 16);
        if (w > 16384)
            w = 16384;
        if (w < -16384)
            w = -16384;
        return w[15:0];
    endfunction

    function automatic longint isqrt(longint s);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > s)
            b = b >>> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic longint unit_part(longint a, longint r);
        longint mag;
        longint q;
        mag = (a < 0) ? -a : a;
        q = ((mag <<< 30) + (r >>> 1)) / r;
        return (a < 0) ? -q : q;
    endfunction

    function automatic matrix_item_t rotation_of(axis_item_t it);
        matrix_item_t res;
        longint ax, ay, az, sumsq, r, nx, ny, nz, ang, z, cx, cy, dx, dy;
        longint c, s, t, txy, txz, tyz;
        longint e[9];
        bit flip;
        ax = it.axis_x;
        ay = it.axis_y;
        az = it.axis_z;
        sumsq = ax * ax + ay * ay + az * az;
        res = '0;
        if (sumsq == 0)
        begin
            res.m00 = ONE_Q14;
            res.m11 = ONE_Q14;
            res.m22 = ONE_Q14;
            res.axis_zero = 1'b1;
            return res;
        end
        r = isqrt(sumsq);
        nx = unit_part(ax, r);
        ny = unit_part(ay, r);
        nz = unit_part(az, r);
        ang = it.turn_angle;
        flip = 0;
        if (ang >= 16384 && ang < 49152)
        begin
            ang = ang - 32768;
            flip = 1;
        end
        else if (ang >= 49152)
            ang = ang - 65536;
        z = ang * 65536;
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < CORDIC_STAGES && i < MAX_STAGES; i++)
        begin
            dx = fshift(cy, i);
            dy = fshift(cx, i);
            if (z >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                z = z - longint'(atan_turn(i[4:0]));
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                z = z + longint'(atan_turn(i[4:0]));
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
        t = (64'sd1 <<< 30) - c;
        txy = q30_mul(t, q30_mul(nx, ny));
        txz = q30_mul(t, q30_mul(nx, nz));
        tyz = q30_mul(t, q30_mul(ny, nz));
        e[0] = c + q30_mul(t, q30_mul(nx, nx));
        e[1] = txy - q30_mul(s, nz);
        e[2] = txz + q30_mul(s, ny);
        e[3] = txy + q30_mul(s, nz);
        e[4] = c + q30_mul(t, q30_mul(ny, ny));
        e[5] = tyz - q30_mul(s, nx);
        e[6] = txz - q30_mul(s, ny);
        e[7] = tyz + q30_mul(s, nx);
        e[8] = c + q30_mul(t, q30_mul(nz, nz));
        res.m00 = to_entry(e[0]);
        res.m01 = to_entry(e[1]);
        res.m02 = to_entry(e[2]);
        res.m10 = to_entry(e[3]);
        res.m11 = to_entry(e[4]);
        res.m12 = to_entry(e[5]);
        res.m20 = to_entry(e[6]);
        res.m21 = to_entry(e[7]);
        res.m22 = to_entry(e[8]);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic compare_field(string what, logic signed [15:0] got,
                                 logic signed [15:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    initial
        fail_count = 0;

    assign pending_count = pending_matrices.size();

    always @(posedge clk)
    begin
        matrix_item_t want;
        if (rst_n)
        begin
            if (matrix_valid && !matrix_stall)
            begin
                if (pending_matrices.size() == 0)
                    report_mismatch("unexpected matrix beat", 0, 0);
                else
                begin
                    want = pending_matrices.pop_front();
                    compare_field("m00", matrix.m00, want.m00);
                    compare_field("m01", matrix.m01, want.m01);
                    compare_field("m02", matrix.m02, want.m02);
                    compare_field("m10", matrix.m10, want.m10);
                    compare_field("m11", matrix.m11, want.m11);
                    compare_field("m12", matrix.m12, want.m12);
                    compare_field("m20", matrix.m20, want.m20);
                    compare_field("m21", matrix.m21, want.m21);
                    compare_field("m22", matrix.m22, want.m22);
                    if (matrix.axis_zero !== want.axis_zero)
                        report_mismatch("axis_zero", matrix.axis_zero, want.axis_zero);
                end
            end
            if (axis_valid && !axis_stall)
                pending_matrices.push_back(rotation_of(axis));
        end
    end
endmodule

>>> sim/tb_axis_angle_rotation_matrix.sv
// Testbench top for axis_angle_rotation_matrix: drives axis beats with random
// gaps and output stalls, and gives the verdict. Uses aar_pkg and aar_matrix_checker.
`timescale 1ns / 100ps
module tb_axis_angle_rotation_matrix;
    import aar_pkg::*;

    localparam int RANDOM_BEATS = 1200;
    localparam longint CYCLE_LIMIT = 200000;

    logic         clk;
    logic         rst_n;
    logic         axis_valid;
    logic         axis_stall;
    axis_item_t   axis;
    logic         matrix_valid;
    logic         matrix_stall;
    matrix_item_t matrix;
    int           fail_count;
    int           pending_count;
    longint       cycle_count;
    bit           stall_free;

    axis_angle_rotation_matrix u_top (
        .clk(clk), .rst_n(rst_n),
        .axis_valid(axis_valid), .axis_stall(axis_stall), .axis(axis),
        .matrix_valid(matrix_valid), .matrix_stall(matrix_stall), .matrix(matrix)
    );

    aar_matrix_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .axis_valid(axis_valid), .axis_stall(axis_stall), .axis(axis),
        .matrix_valid(matrix_valid), .matrix_stall(matrix_stall), .matrix(matrix),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb_axis_angle_rotation_matrix: FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stall lengths, with stretches where it never stalls.
    initial
    begin
        int wait_cycles;
        matrix_stall = 1'b0;
        stall_free = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (matrix_valid && !matrix_stall)
            begin
                wait_cycles = stall_free ? 0 : $urandom_range(0, 16);
                if (wait_cycles > 0)
                begin
                    matrix_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                    matrix_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_beat(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             logic [15:0] ang, int gap);
        if (gap > 0)
        begin
            axis_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        axis_valid <= 1'b1;
        axis.axis_x <= x;
        axis.axis_y <= y;
        axis.axis_z <= z;
        axis.turn_angle <= ang;
        do
            @(posedge clk);
        while (axis_stall);
    endtask

    function automatic logic [15:0] pick_component();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 3) * 16384);
            1: return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int gap;
        rst_n = 1'b0;
        axis_valid = 1'b0;
        axis = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero axis, extreme components, quadrant boundaries of the angle.
        send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_beat(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 0);
        send_beat(16'h7FFF, 16'h0000, 16'h0000, 16'h4000, 0);
        send_beat(16'h8000, 16'h0000, 16'h0000, 16'h4000, 0);
        send_beat(16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 1);
        send_beat(16'h0000, 16'h0000, 16'h8000, 16'hC000, 0);
        send_beat(16'h8000, 16'h8000, 16'h8000, 16'h3FFF, 0);
        send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hBFFF, 2);
        send_beat(16'h0001, 16'h0000, 16'h0000, 16'h0001, 0);
        send_beat(16'hFFFF, 16'h0001, 16'hFFFF, 16'h2000, 0);
        send_beat(16'h0003, 16'h0004, 16'h0000, 16'hE000, 0);
        send_beat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0);
        send_beat(16'h0001, 16'h8000, 16'h7FFF, 16'h0000, 0);
        send_beat(16'h0000, 16'h0000, 16'h0000, 16'h1234, 0);
        send_beat(16'h0000, 16'h0001, 16'h0001, 16'h4001, 0);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 2)
            begin
                // Let the pipeline drain completely before going on.
                axis_valid <= 1'b0;
                @(posedge clk);
                while (pending_count != 0)
                    @(posedge clk);
            end
            stall_free = (n % 300) >= 250;
            gap = ((n % 300) >= 200 && (n % 300) < 250) ? 0 : $urandom_range(0, 16);
            send_beat(pick_component(), pick_component(), pick_component(),
                      pick_angle(), gap);
        end
        axis_valid <= 1'b0;
        @(posedge clk);

        while (pending_count != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("tb_axis_angle_rotation_matrix: PASS");
        else
            $display("tb_axis_angle_rotation_matrix: FAIL");
        $finish;
    end
endmodule
